[rtl/bms_pkg.sv]
package bms_pkg;

    localparam int ROW_W = 16;
    localparam int IDX_W = 4;

    typedef struct packed {
        logic [ROW_W-1:0] row_bits;
        logic             last_row;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] reach_bits;
        logic             last;
    } out_word_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SRC  = 5'b00010,
        ST_LSRC = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

endpackage

[rtl/boolean_matrix_square_top.sv]
// Channel | Direction | Handshake             | Word
// in      | input     | in_valid / in_stall   | bms_pkg::in_word_t  (row_bits, last_row)
// out     | output    | out_valid / out_stall | bms_pkg::out_word_t (row_index, reach_bits, last)
//
// A row that is not last is written to the row store; while idle the block takes one row per cycle.
// After the last row (or the row that fills the store) the block emits n result rows.
// Each result row takes one read of the source row, then one
// read of the row store per column, all through the single read port of the store.
// Reset clears the row count and the sequencer; the row store itself needs no clearing.
// A stalled output holds the emit state; no row is accepted until the burst is done.
module boolean_matrix_square_top #(
    parameter int MAX_NODES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bms_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output bms_pkg::out_word_t  out_word
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW = $clog2(MAX_NODES + 1);

    bms_pkg::state_t state_reg, state_next;

    logic [NW-1:0]             count_reg, count_next;
    logic [NW-1:0]             n_reg, n_next;
    logic [AW-1:0]             i_reg, i_next;
    logic [AW-1:0]             j_reg, j_next;
    logic [bms_pkg::ROW_W-1:0] src_reg, src_next;
    logic [bms_pkg::ROW_W-1:0] acc_reg, acc_next;
    logic                      out_valid_reg, out_valid_next;
    bms_pkg::out_word_t        out_word_reg, out_word_next;

    logic                      in_fire;
    logic [NW-1:0]             count_inc;
    logic                      we;
    logic [AW-1:0]             raddr;
    logic [bms_pkg::ROW_W-1:0] rdata;
    logic [bms_pkg::ROW_W-1:0] mask;
    logic [AW-1:0]             lim_m1;
    logic                      i_last;
    logic                      out_free;

    bms_row_mem #(
        .DEPTH  (MAX_NODES),
        .ADDR_W (AW)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_word.row_bits),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_stall  = (state_reg != bms_pkg::ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign we        = in_fire;
    assign count_inc = count_reg + 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign i_last    = (NW'(i_reg) == n_reg - 1'b1);

    // Columns at or above the node count are neither followed nor reported.
    always_comb
    begin
        for (int k = 0; k < bms_pkg::ROW_W; k++)
        begin
            mask[k] = (k < int'(n_reg));
        end
    end

    // Only the first 16 nodes can carry an edge, so the column scan stops there.
    assign lim_m1 = (int'(n_reg) > bms_pkg::ROW_W) ? AW'(bms_pkg::ROW_W - 1)
                                                   : AW'(n_reg - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        src_next       = src_reg;
        acc_next       = acc_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg;
        raddr          = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bms_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    count_next = count_inc;
                    if (in_word.last_row || (int'(count_inc) >= MAX_NODES))
                    begin
                        n_next     = count_inc;
                        i_next     = '0;
                        state_next = bms_pkg::ST_SRC;
                    end
                end
            end
            bms_pkg::ST_SRC:
            begin
                raddr      = i_reg;
                state_next = bms_pkg::ST_LSRC;
            end
            bms_pkg::ST_LSRC:
            begin
                src_next   = rdata & mask;
                acc_next   = '0;
                j_next     = '0;
                raddr      = '0;
                state_next = bms_pkg::ST_SCAN;
            end
            bms_pkg::ST_SCAN:
            begin
                // The read data belongs to column j, whose address was issued in the previous cycle.
                if (src_reg[4'(j_reg)])
                begin
                    acc_next = acc_reg | (rdata & mask);
                end
                if (j_reg == lim_m1)
                begin
                    state_next = bms_pkg::ST_EMIT;
                end
                else
                begin
                    raddr  = j_reg + 1'b1;
                    j_next = j_reg + 1'b1;
                end
            end
            bms_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next.row_index  = bms_pkg::IDX_W'(i_reg);
                    out_word_next.reach_bits = acc_reg;
                    out_word_next.last       = i_last;
                    if (i_last)
                    begin
                        count_next = '0;
                        state_next = bms_pkg::ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = bms_pkg::ST_SRC;
                    end
                end
            end
            default:
            begin
                state_next = bms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bms_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        src_reg      <= src_next;
        acc_reg      <= acc_next;
        out_word_reg <= out_word_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_NODES)
        else $error("row count beyond store depth");

    a_last_starts_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_word.last_row) |=> (state_reg == bms_pkg::ST_SRC))
        else $error("last row did not start the result burst");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bms_pkg::ST_EMIT && out_free && i_last)
        |=> (count_reg == '0 && state_reg == bms_pkg::ST_IDLE && out_valid_reg
             && out_word_reg.last))
        else $error("final result row did not clear the store");
`endif

endmodule

[rtl/bms_row_mem.sv]
module bms_row_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [bms_pkg::ROW_W-1:0] wdata,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [bms_pkg::ROW_W-1:0] rdata
);

    logic [bms_pkg::ROW_W-1:0] mem [DEPTH];
    logic [bms_pkg::ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
